[hdl/luma_palette_color_map_top_assert.svh]
// Assertion macros used by the luma palette color map checker.
`ifndef LUMA_PALETTE_COLOR_MAP_TOP_ASSERT_SVH
`define LUMA_PALETTE_COLOR_MAP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LPCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/lpcm_pkg.sv]
// Shared constants, types and palette table builder for the luma palette color map.
`timescale 1ns / 1ps

package lpcm_pkg;

  localparam int LUT_ENTRIES = 256;
  localparam int IDX_W       = $clog2(LUT_ENTRIES);
  localparam int NUM_PAL     = 4;
  localparam int PAL_W       = 2;
  localparam int CH_W        = 8;
  localparam int MAX_STOPS   = 5;

  // Rec.601 weights in thousandths
  localparam int COEF_R  = 299;
  localparam int COEF_G  = 587;
  localparam int COEF_B  = 114;
  localparam int SUM_MAX = 255 * (COEF_R + COEF_G + COEF_B);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);

  // Exact floor(sum * (LUT_ENTRIES-1) / SUM_MAX) by a rounded-up reciprocal
  localparam int RECIP_SHIFT = 38;
  localparam longint unsigned RECIP_MUL =
    ((64'd1 << RECIP_SHIFT) * 64'(LUT_ENTRIES - 1) + 64'(SUM_MAX) - 64'd1) / 64'(SUM_MAX);
  localparam int MUL_W  = $clog2(RECIP_MUL + 64'd1);
  localparam int PROD_W = SUM_W + MUL_W;
  localparam int QUO_W  = PROD_W - RECIP_SHIFT;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_START_PALETTE = 1'b0,
    REG_CYCLE_ON_BEAT = 1'b1
  } reg_idx_e;

  typedef logic [3*CH_W-1:0] rgb_t;

  typedef struct packed {
    logic [9:0] t;
    logic [9:0] r;
    logic [9:0] g;
    logic [9:0] b;
  } stop_t;

  // Gradient stops: position and channels in thousandths
  localparam stop_t STOP_TABLE [NUM_PAL][MAX_STOPS] = '{
    '{ '{0, 0, 0, 0}, '{350, 800, 50, 0}, '{600, 1000, 500, 0},
       '{850, 1000, 900, 200}, '{1000, 1000, 1000, 1000} },
    '{ '{0, 0, 0, 0}, '{400, 0, 150, 550}, '{750, 0, 800, 900},
       '{1000, 1000, 1000, 1000}, '{1000, 1000, 1000, 1000} },
    '{ '{0, 0, 0, 0}, '{450, 100, 650, 100}, '{800, 700, 950, 100},
       '{1000, 1000, 1000, 1000}, '{1000, 1000, 1000, 1000} },
    '{ '{0, 0, 0, 0}, '{400, 400, 0, 700}, '{750, 950, 200, 800},
       '{1000, 1000, 1000, 1000}, '{1000, 1000, 1000, 1000} }
  };

  localparam int STOP_COUNT [NUM_PAL] = '{5, 4, 4, 4};

  // floor(255 * (va + (vb-va)*num/den) / 1000), saturated at 255; elaboration only
  function automatic logic [CH_W-1:0] lerp_chan(longint unsigned va, longint unsigned vb,
                                                longint unsigned num, longint unsigned den);
    longint unsigned diff;
    longint unsigned top;
    longint unsigned step;
    logic [CH_W-1:0] q;
    diff = (vb >= va) ? (vb - va) : 64'd0;
    top  = 64'd255 * (va * den + diff * num);
    step = 64'd1000 * den;
    q    = '0;
    for (int k = 1; k < 256; k++) begin
      if (64'(k) * step <= top) q = CH_W'(k);
    end
    return q;
  endfunction

  // One palette entry: interpolate between the stops that bracket i/(LUT_ENTRIES-1)
  function automatic rgb_t pal_entry(int p, int i);
    longint unsigned span;
    longint unsigned ti;
    longint unsigned base;
    longint unsigned num;
    longint unsigned den;
    int    s;
    int    s2;
    int    n;
    logic  done;
    stop_t a;
    stop_t b;
    span = 64'(LUT_ENTRIES - 1);
    ti   = 64'd1000 * 64'(i);
    n    = STOP_COUNT[p];
    s    = 0;
    done = 1'b0;
    for (int k = 0; k < MAX_STOPS - 1; k++) begin
      if (!done && (s + 1 < n) && (64'(STOP_TABLE[p][s + 1].t) * span < ti)) s = s + 1;
      else done = 1'b1;
    end
    s2   = (s + 1 < n) ? s + 1 : s;
    a    = STOP_TABLE[p][s];
    b    = STOP_TABLE[p][s2];
    base = 64'(a.t) * span;
    num  = (ti > base) ? ti - base : 64'd0;
    den  = (b.t > a.t) ? 64'(b.t - a.t) * span : 64'd0;
    if (den == 64'd0) begin
      den = 64'd1;
      num = 64'd0;
    end
    if (num > den) num = den;
    return {lerp_chan(64'(a.r), 64'(b.r), num, den),
            lerp_chan(64'(a.g), 64'(b.g), num, den),
            lerp_chan(64'(a.b), 64'(b.b), num, den)};
  endfunction

endpackage

[hdl/lpcm_luma.sv]
// Weighted Rec.601 luma sum of one RGB pixel.
`timescale 1ns / 1ps

module lpcm_luma (
  input  logic [lpcm_pkg::CH_W-1:0]  red_i,
  input  logic [lpcm_pkg::CH_W-1:0]  green_i,
  input  logic [lpcm_pkg::CH_W-1:0]  blue_i,
  output logic [lpcm_pkg::SUM_W-1:0] sum_o
);
  import lpcm_pkg::*;

  // constant weights only: shift-and-add terms
  assign sum_o = SUM_W'(red_i * COEF_R + green_i * COEF_G + blue_i * COEF_B);

endmodule

[hdl/lpcm_index.sv]
// Scales the luma sum to a palette index through a reciprocal multiply.
`timescale 1ns / 1ps

module lpcm_index (
  input  logic [lpcm_pkg::SUM_W-1:0] sum_i,
  output logic [lpcm_pkg::IDX_W-1:0] idx_o
);
  import lpcm_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;

  assign prod = PROD_W'(sum_i) * PROD_W'(RECIP_MUL);
  assign quo  = prod[PROD_W-1:RECIP_SHIFT];

  always_comb begin
    if (quo > QUO_W'(LUT_ENTRIES - 1)) idx_o = IDX_W'(LUT_ENTRIES - 1);
    else idx_o = quo[IDX_W-1:0];
  end

endmodule

[hdl/lpcm_lut.sv]
// Fixed gradient palette tables and palette select.
`timescale 1ns / 1ps

module lpcm_lut (
  input  logic [lpcm_pkg::IDX_W-1:0] idx_i,
  input  logic [lpcm_pkg::PAL_W-1:0] pal_i,
  output lpcm_pkg::rgb_t             rgb_o
);
  import lpcm_pkg::*;

  rgb_t tbl [NUM_PAL][LUT_ENTRIES];
  rgb_t rd  [NUM_PAL];

  for (genvar p = 0; p < NUM_PAL; p++) begin : g_pal
    for (genvar i = 0; i < LUT_ENTRIES; i++) begin : g_ent
      localparam rgb_t ENTRY = pal_entry(p, i);
      assign tbl[p][i] = ENTRY;
    end
    assign rd[p] = tbl[p][idx_i];
  end

  assign rgb_o = rd[pal_i];

endmodule

[hdl/luma_palette_color_map_top.sv]
// Top level of the luma palette color map: handshake, pipeline and registers.
`timescale 1ns / 1ps

// Recolors an RGB pixel stream through one of four gradient palettes by luma.
// Input channel: in_valid_i/in_ready_o carry one pixel beat with frame_start
// and beat_seen flags. Output channel: out_valid_o/out_ready_i carry the mapped
// color and the palette index used for that pixel.
// Path: a pixel accepted into the luma sum register moves on through the palette
// index register to the result register, from which it leaves on the output.
// Throughput: one pixel per cycle while out_ready_i is high, set by the three-stage
// register pipeline; the palette tables are read combinationally.
// Palette: loaded from start_palette on reset and on every write of it; with
// cycle_on_beat set, a frame-start pixel carrying a beat advances it first.
// Reset: pipeline empty, palette fire (0), cycling off.
// Stall: while out_ready_i is low the result holds; in_ready_o stays high as
// long as an earlier stage is free, so up to three pixels can be held.
// Config (APB): start_palette at 0x0, cycle_on_beat at 0x4; write only while idle.
module luma_palette_color_map_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpcm_pkg::CH_W-1:0]     red_in_i,
  input  logic [lpcm_pkg::CH_W-1:0]     green_in_i,
  input  logic [lpcm_pkg::CH_W-1:0]     blue_in_i,
  input  logic                          frame_start_i,
  input  logic                          beat_seen_i,
  // mapped output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpcm_pkg::CH_W-1:0]     red_out_o,
  output logic [lpcm_pkg::CH_W-1:0]     green_out_o,
  output logic [lpcm_pkg::CH_W-1:0]     blue_out_o,
  output logic [lpcm_pkg::PAL_W-1:0]    palette_used_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpcm_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpcm_pkg::DATA_W-1:0]   pwdata,
  output logic [lpcm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lpcm_pkg::*;

  // configuration and palette state
  logic [PAL_W-1:0] start_pal_q, start_pal_d;
  logic             cycle_q, cycle_d;
  logic [PAL_W-1:0] cur_pal_q, cur_pal_d;
  logic [PAL_W-1:0] map_pal;
  logic             wr_en;
  logic             in_acc;
  reg_idx_e         reg_sel;

  // pipeline control
  logic adv1, adv2, adv3;
  logic s1_vld_q, s2_vld_q, out_vld_q;

  // pipeline payload
  logic [SUM_W-1:0] sum_c;
  logic [IDX_W-1:0] idx_c;
  rgb_t             rgb_c;
  logic [SUM_W-1:0] s1_sum_q;
  logic [PAL_W-1:0] s1_pal_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [PAL_W-1:0] s2_pal_q;
  rgb_t             out_rgb_q;
  logic [PAL_W-1:0] out_pal_q;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, register picked by the word address bit
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_sel)
      REG_START_PALETTE: prdata = DATA_W'(start_pal_q);
      REG_CYCLE_ON_BEAT: prdata = DATA_W'(cycle_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Palette selection: with cycle_on_beat set, advance on a beat at frame start
  // before mapping; a write of start_palette reloads the current palette.
  // ---------------------------------------------------------------------------
  assign in_acc  = in_valid_i && in_ready_o;
  assign map_pal = (cycle_q && frame_start_i && beat_seen_i) ? cur_pal_q + 1'b1 : cur_pal_q;

  always_comb begin
    start_pal_d = start_pal_q;
    cycle_d     = cycle_q;
    cur_pal_d   = cur_pal_q;
    if (in_acc) cur_pal_d = map_pal;
    if (wr_en) begin
      case (reg_sel)
        REG_START_PALETTE: begin
          start_pal_d = pwdata[PAL_W-1:0];
          cur_pal_d   = pwdata[PAL_W-1:0];
        end
        REG_CYCLE_ON_BEAT: cycle_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pal_q <= '0;
      cycle_q     <= 1'b0;
      cur_pal_q   <= '0;
    end else begin
      start_pal_q <= start_pal_d;
      cycle_q     <= cycle_d;
      cur_pal_q   <= cur_pal_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow: a stage loads when it is empty or its content moves on.
  // Any free stage keeps in_ready_o high while the output waits.
  // ---------------------------------------------------------------------------
  assign adv3       = !out_vld_q || out_ready_i;
  assign adv2       = !s2_vld_q || adv3;
  assign adv1       = !s1_vld_q || adv2;
  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv1) s1_vld_q  <= in_valid_i;
      if (adv2) s2_vld_q  <= s1_vld_q;
      if (adv3) out_vld_q <= s2_vld_q;
    end
  end

  // stage 1: weighted luma sum
  lpcm_luma u_luma (
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .sum_o   (sum_c)
  );

  // stage 2: scale to palette index
  lpcm_index u_index (
    .sum_i (s1_sum_q),
    .idx_o (idx_c)
  );

  // stage 3: palette lookup
  lpcm_lut u_lut (
    .idx_i (s2_idx_q),
    .pal_i (s2_pal_q),
    .rgb_o (rgb_c)
  );

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      s1_sum_q <= sum_c;
      s1_pal_q <= map_pal;
    end
    if (adv2 && s1_vld_q) begin
      s2_idx_q <= idx_c;
      s2_pal_q <= s1_pal_q;
    end
    if (adv3 && s2_vld_q) begin
      out_rgb_q <= rgb_c;
      out_pal_q <= s2_pal_q;
    end
  end

  // hold the result beat until taken
  assign out_valid_o    = out_vld_q;
  assign red_out_o      = out_rgb_q[3*CH_W-1:2*CH_W];
  assign green_out_o    = out_rgb_q[2*CH_W-1:CH_W];
  assign blue_out_o     = out_rgb_q[CH_W-1:0];
  assign palette_used_o = out_pal_q;

endmodule

[hdl/lpcm_checker.sv]
// Port-level assertion checker for the luma palette color map, with its bind.
`timescale 1ns / 1ps
`include "luma_palette_color_map_top_assert.svh"

module lpcm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [lpcm_pkg::CH_W-1:0]   red_out_o,
  input logic [lpcm_pkg::CH_W-1:0]   green_out_o,
  input logic [lpcm_pkg::CH_W-1:0]   blue_out_o,
  input logic [lpcm_pkg::PAL_W-1:0]  palette_used_o
);

  // a stalled result beat stays valid
  `LPCM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped while stalled")

  // a stalled result beat keeps its payload
  `LPCM_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(palette_used_o), "stalled result changed")

  // a draining output never backs up the input
  `LPCM_ASSERT_IMP(a_no_false_stall, out_ready_i, in_ready_o, "input stalled with output ready")

  // with the output always taken, a pixel passes the sum, index and result registers to the output
  `LPCM_ASSERT_NXT(a_latency, in_valid_i && in_ready_o && out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o, "result missing after pipeline latency")

endmodule

bind luma_palette_color_map_top lpcm_checker u_lpcm_checker (.*);
